>>> src/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

    localparam int NUM_W       = 12;
    localparam int CHAR_W      = 8;
    localparam int SYM_COUNT   = 13;
    localparam int SYM_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [NUM_W-1:0]  MAX_NUMERAL = 12'd3999;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    // Greedy symbol table, largest value first.
    localparam logic [NUM_W-1:0] SYM_VALUE [SYM_COUNT] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [CHAR_W-1:0] SYM_FIRST [SYM_COUNT] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };
    // A zero entry marks a symbol of a single letter.
    localparam logic [CHAR_W-1:0] SYM_SECOND [SYM_COUNT] = '{
        CHAR_NONE, "M", CHAR_NONE, "D", CHAR_NONE, "C", CHAR_NONE, "L",
        CHAR_NONE, "X", CHAR_NONE, "V", CHAR_NONE
    };

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_RANGE,
        KIND_NUMERAL
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [NUM_W-1:0] number;
    } job_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              no_char;
        logic              out_of_range;
    } result_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_link_t;

endpackage

`default_nettype wire

>>> src/i2r_num_if.sv
`default_nettype none

interface i2r_num_if
    import i2r_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

`default_nettype wire

>>> src/i2r_char_if.sv
`default_nettype none

interface i2r_char_if
    import i2r_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              no_char;
    logic              out_of_range;

    modport source (
        output valid, output char_code, output is_last, output no_char,
        output out_of_range, input ready
    );
    modport sink (
        input valid, input char_code, input is_last, input no_char,
        input out_of_range, output ready
    );
endinterface

`default_nettype wire

>>> src/i2r_front.sv
`default_nettype none

module i2r_front
    import i2r_pkg::*;
(
    i2r_num_if.sink numbers,
    output job_link_t push,
    input  wire logic push_ready
);

    kind_t kind;

    always_comb
    begin
        priority if (numbers.number == '0)
        begin
            kind = KIND_ZERO;
        end
        else if (numbers.number > MAX_NUMERAL)
        begin
            kind = KIND_RANGE;
        end
        else
        begin
            kind = KIND_NUMERAL;
        end
    end

    assign numbers.ready   = push_ready;
    assign push.valid      = numbers.valid;
    assign push.job.kind   = kind;
    assign push.job.number = numbers.number;

endmodule

`default_nettype wire

>>> src/i2r_queue.sv
`default_nettype none

module i2r_queue
    import i2r_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_link_t push,
    output logic           push_ready,
    output job_link_t      head,
    input  wire logic      pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = (count_reg != '0) && pop_ready;

    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

`default_nettype wire

>>> src/i2r_back.sv
`default_nettype none

module i2r_back
    import i2r_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_link_t head,
    output logic           pop_ready,
    i2r_char_if.source     letters
);

    logic              active_reg, active_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic [CHAR_W-1:0] pend_char_reg, pend_char_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic                 slot_free;
    logic                 do_pop;
    logic                 do_emit;
    logic [SYM_IDX_W-1:0] sym_idx;
    logic [NUM_W-1:0]     diff;
    logic [CHAR_W-1:0]    second;

    assign slot_free = !out_valid_reg || letters.ready;
    assign pop_ready = !active_reg && slot_free;
    assign do_pop    = head.valid && pop_ready;
    assign do_emit   = active_reg && slot_free;

    // The remainder only shrinks, so the first table entry that still fits
    // is always the one the greedy walk would reach.
    always_comb
    begin
        sym_idx = SYM_IDX_W'(SYM_COUNT - 1);
        for (int i = SYM_COUNT - 1; i >= 0; i--)
        begin
            if (rem_reg >= SYM_VALUE[i])
            begin
                sym_idx = SYM_IDX_W'(i);
            end
        end
    end

    assign diff   = rem_reg - SYM_VALUE[sym_idx];
    assign second = SYM_SECOND[sym_idx];

    always_comb
    begin
        active_next    = active_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !letters.ready;

        if (do_emit)
        begin
            out_valid_next        = 1'b1;
            out_next.no_char      = 1'b0;
            out_next.out_of_range = 1'b0;
            if (pend_reg)
            begin
                out_next.char_code = pend_char_reg;
                out_next.is_last   = (rem_reg == '0);
                pend_next          = 1'b0;
                active_next        = (rem_reg != '0);
            end
            else
            begin
                out_next.char_code = SYM_FIRST[sym_idx];
                out_next.is_last   = (diff == '0) && (second == CHAR_NONE);
                rem_next           = diff;
                pend_next          = (second != CHAR_NONE);
                pend_char_next     = second;
                active_next        = !((diff == '0) && (second == CHAR_NONE));
            end
        end
        else if (do_pop)
        begin
            unique case (head.job.kind)
                KIND_NUMERAL:
                begin
                    rem_next    = head.job.number;
                    pend_next   = 1'b0;
                    active_next = 1'b1;
                end
                KIND_RANGE:
                begin
                    out_valid_next        = 1'b1;
                    out_next.char_code    = CHAR_NONE;
                    out_next.is_last      = 1'b1;
                    out_next.no_char      = 1'b1;
                    out_next.out_of_range = 1'b1;
                end
                default:
                begin
                    out_valid_next        = 1'b1;
                    out_next.char_code    = CHAR_NONE;
                    out_next.is_last      = 1'b1;
                    out_next.no_char      = 1'b1;
                    out_next.out_of_range = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        pend_char_reg <= pend_char_next;
        out_reg       <= out_next;
    end

    assign letters.valid        = out_valid_reg;
    assign letters.char_code    = out_reg.char_code;
    assign letters.is_last      = out_reg.is_last;
    assign letters.no_char      = out_reg.no_char;
    assign letters.out_of_range = out_reg.out_of_range;

endmodule

`default_nettype wire

>>> src/integer_to_roman_emitter.sv
`default_nettype none

// Converts each 12-bit number taken on the numbers channel into its Roman
// numeral, sent on the letters channel as one ASCII letter per transaction,
// most significant letter first, with is_last set on the final letter.
// Zero gives one transaction with no_char set, and a number above 3999 gives
// one transaction with no_char and out_of_range set. For a numeral the
// emitter first loads the number, then gives one letter per cycle while the
// letters channel takes them; 3888 gives the longest numeral, 15 letters.
// The emitter takes no new number until the last letter is formed.
// A two-entry queue after the classifier lets new numbers be taken while the
// emitter works, and the registered output lets the next letter be formed
// in the cycle in which the current one is taken.
module integer_to_roman_emitter
    import i2r_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    i2r_num_if.sink    numbers,
    i2r_char_if.source letters
);

    job_link_t push;
    job_link_t head;
    logic      push_ready;
    logic      pop_ready;

    i2r_front u_front (
        .numbers    (numbers),
        .push       (push),
        .push_ready (push_ready)
    );

    i2r_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop_ready  (pop_ready)
    );

    i2r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop_ready (pop_ready),
        .letters   (letters)
    );

endmodule

`default_nettype wire
